// ===== src/mhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

    // result status carried on the master-side tuser
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // request kind carried on the slave-side tuser
    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

endpackage

`default_nettype wire

// ===== src/mhpq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/min_heap_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// binary min-heap in one single-port-write ram with a registered read port, one beat in flight
// insert: the new entry climbs one level per sift step while its parent is strictly greater
// extract: the last entry refills the root and sinks, reading the left child and then the right one
// if present; refused beats and the only entry out go straight to the result
// each sift step waits one ram read; s_tready returns as the result is registered
// reset (rst_n, asynchronous) empties the heap; ram contents are left as they are

module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int DEPTH    = 256,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // request side
    input  wire logic s_tvalid,
    output logic      s_tready,
    // key, tag
    input  wire logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] s_tdata,
    // action
    input  wire logic s_tuser,
    // result side
    output logic      m_tvalid,
    input  wire logic m_tready,
    // removed_key, removed_tag, min_key, min_tag, entry_total
    output logic [((2*KEY_BITS+2*TAG_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0] m_tuser
);

    localparam int AW = $clog2(DEPTH);           // ram address bits
    localparam int CW = $clog2(DEPTH + 1);       // entry count bits
    localparam int XW = AW + 2;                  // child index bits, room for 2*h+2
    localparam int EW = KEY_BITS + TAG_BITS;     // ram word: tag above key
    localparam int OW = ((2*KEY_BITS + 2*TAG_BITS + CW + 7) / 8) * 8;

    typedef enum logic [2:0] {
        IDLE,
        SIFT_UP,
        LOAD_LAST,
        READ_LEFT,
        READ_RIGHT,
        PLACE,
        FINISH
    } state_t;

    state_t                state_reg,    state_next;
    logic [CW-1:0]         cnt_reg,      cnt_next;
    logic [AW-1:0]         hole_reg,     hole_next;
    logic [KEY_BITS-1:0]   mov_key_reg,  mov_key_next;
    logic [TAG_BITS-1:0]   mov_tag_reg,  mov_tag_next;
    logic [KEY_BITS-1:0]   left_key_reg, left_key_next;
    logic [TAG_BITS-1:0]   left_tag_reg, left_tag_next;
    logic [KEY_BITS-1:0]   root_key_reg, root_key_next;
    logic [TAG_BITS-1:0]   root_tag_reg, root_tag_next;
    logic [KEY_BITS-1:0]   rem_key_reg,  rem_key_next;
    logic [TAG_BITS-1:0]   rem_tag_reg,  rem_tag_next;
    status_t               status_reg,   status_next;
    logic                  m_valid_reg,  m_valid_next;
    logic [1:0]            m_user_reg,   m_user_next;
    logic [OW-1:0]         m_data_reg,   m_data_next;

    // ram port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;

    // request beat fields
    logic                  in_fire;
    logic [KEY_BITS-1:0]   in_key;
    logic [TAG_BITS-1:0]   in_tag;

    logic [KEY_BITS-1:0]   rd_key;
    logic [TAG_BITS-1:0]   rd_tag;
    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         hole_left;
    logic [XW-1:0]         hole_right;
    logic [AW-1:0]         hole_up;
    logic [AW-1:0]         cnt_idx;
    logic [AW-1:0]         last_idx;

    // sift-down candidate child
    logic [KEY_BITS-1:0]   c_key;
    logic [TAG_BITS-1:0]   c_tag;
    logic [AW-1:0]         c_idx;
    logic [XW-1:0]         c_left;
    logic [AW-1:0]         up_up;
    logic                  out_free;

    mhpq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_key   = s_tdata[KEY_BITS-1:0];
    assign in_tag   = s_tdata[EW-1:KEY_BITS];

    assign rd_key   = ram_rdata[KEY_BITS-1:0];
    assign rd_tag   = ram_rdata[EW-1:KEY_BITS];

    assign cnt_x      = XW'(cnt_reg);
    assign hole_left  = {1'b0, hole_reg, 1'b1};
    assign hole_right = hole_left + 1'b1;
    assign hole_up    = (hole_reg - 1'b1) >> 1;
    assign up_up      = (hole_up - 1'b1) >> 1;
    assign cnt_idx    = cnt_reg[AW-1:0];
    assign last_idx   = AW'(cnt_reg - 1'b1);
    assign out_free   = !m_valid_reg || m_tready;

    // smaller child, left wins a tie
    always_comb
    begin
        if (state_reg == READ_RIGHT && rd_key < left_key_reg)
        begin
            c_key = rd_key;
            c_tag = rd_tag;
            c_idx = hole_right[AW-1:0];
        end
        else if (state_reg == READ_RIGHT)
        begin
            c_key = left_key_reg;
            c_tag = left_tag_reg;
            c_idx = hole_left[AW-1:0];
        end
        else
        begin
            c_key = rd_key;
            c_tag = rd_tag;
            c_idx = hole_left[AW-1:0];
        end
        c_left = {1'b0, c_idx, 1'b1};
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        hole_next     = hole_reg;
        mov_key_next  = mov_key_reg;
        mov_tag_next  = mov_tag_reg;
        left_key_next = left_key_reg;
        left_tag_next = left_tag_reg;
        rem_key_next  = rem_key_reg;
        rem_tag_next  = rem_tag_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_user_next   = m_user_reg;
        m_data_next   = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = hole_reg;
        ram_wdata = {mov_tag_reg, mov_key_reg};
        ram_raddr = '0;

        case (state_reg)
            IDLE:
            begin
                if (in_fire)
                begin
                    rem_key_next = '0;
                    rem_tag_next = '0;
                    status_next  = STATUS_DONE;
                    if (s_tuser == ACT_INSERT)
                    begin
                        if (cnt_reg == CW'(DEPTH))
                        begin
                            status_next = STATUS_FULL;
                            state_next  = FINISH;
                        end
                        else
                        begin
                            cnt_next     = cnt_reg + 1'b1;
                            mov_key_next = in_key;
                            mov_tag_next = in_tag;
                            hole_next    = cnt_idx;
                            if (cnt_reg == '0)
                            begin
                                state_next = PLACE;
                            end
                            else
                            begin
                                // fetch the parent of the new slot
                                ram_raddr  = (cnt_idx - 1'b1) >> 1;
                                state_next = SIFT_UP;
                            end
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                            state_next  = FINISH;
                        end
                        else
                        begin
                            rem_key_next = root_key_reg;
                            rem_tag_next = root_tag_reg;
                            cnt_next     = cnt_reg - 1'b1;
                            if (cnt_reg == CW'(1))
                            begin
                                state_next = FINISH;
                            end
                            else
                            begin
                                // fetch the last entry, it refills the root
                                ram_raddr  = last_idx;
                                state_next = LOAD_LAST;
                            end
                        end
                    end
                end
            end

            SIFT_UP:
            begin
                // read data is the parent of the hole
                if (rd_key > mov_key_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    hole_next = hole_up;
                    if (hole_up == '0)
                    begin
                        state_next = PLACE;
                    end
                    else
                    begin
                        ram_raddr = up_up;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = FINISH;
                end
            end

            LOAD_LAST:
            begin
                mov_key_next = rd_key;
                mov_tag_next = rd_tag;
                hole_next    = '0;
                if (cnt_reg > CW'(1))
                begin
                    ram_raddr  = AW'(1);
                    state_next = READ_LEFT;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = ram_rdata;
                    state_next = FINISH;
                end
            end

            READ_LEFT,
            READ_RIGHT:
            begin
                left_key_next = rd_key;
                left_tag_next = rd_tag;
                if (state_reg == READ_LEFT && hole_right < cnt_x)
                begin
                    ram_raddr  = hole_right[AW-1:0];
                    state_next = READ_RIGHT;
                end
                else if (c_key < mov_key_reg)
                begin
                    // child moves up into the hole
                    ram_we    = 1'b1;
                    ram_wdata = {c_tag, c_key};
                    hole_next = c_idx;
                    if (c_left < cnt_x)
                    begin
                        ram_raddr  = c_left[AW-1:0];
                        state_next = READ_LEFT;
                    end
                    else
                    begin
                        state_next = PLACE;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = FINISH;
                end
            end

            PLACE:
            begin
                ram_we     = 1'b1;
                state_next = FINISH;
            end

            FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    if (cnt_reg != '0)
                    begin
                        m_data_next = OW'({cnt_reg, root_tag_reg, root_key_reg,
                                           rem_tag_reg, rem_key_reg});
                    end
                    else
                    begin
                        m_data_next = OW'({cnt_reg, {TAG_BITS{1'b0}}, {KEY_BITS{1'b0}},
                                           rem_tag_reg, rem_key_reg});
                    end
                    state_next = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // shadow copy of the root, kept in step with every write to slot zero
    always_comb
    begin
        root_key_next = root_key_reg;
        root_tag_next = root_tag_reg;
        if (ram_we && ram_waddr == '0)
        begin
            root_key_next = ram_wdata[KEY_BITS-1:0];
            root_tag_next = ram_wdata[EW-1:KEY_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hole_reg     <= hole_next;
        mov_key_reg  <= mov_key_next;
        mov_tag_reg  <= mov_tag_next;
        left_key_reg <= left_key_next;
        left_tag_reg <= left_tag_next;
        root_key_reg <= root_key_next;
        root_tag_reg <= root_tag_next;
        rem_key_reg  <= rem_key_next;
        rem_tag_reg  <= rem_tag_next;
        status_reg   <= status_next;
        m_user_reg   <= m_user_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mhpq_pkg::*;

    localparam int HEAP_DEPTH   = 256;
    localparam int ITEM_TARGET  = 1100;
    localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES  = 40;    // deepest extract is well under this

    // one expected answer of the queue
    typedef struct {
        status_t     status;
        logic [15:0] removed_key;
        logic [7:0]  removed_tag;
        logic [15:0] min_key;
        logic [7:0]  min_tag;
        logic [8:0]  entry_total;
    } heap_answer_t;

    // mirror of the heap array, predicts one answer per accepted request
    class heap_scoreboard;
        logic [15:0]  keys [HEAP_DEPTH];
        logic [7:0]   tags [HEAP_DEPTH];
        int unsigned  fill;
        int unsigned  errors;
        heap_answer_t answers_due [$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic [15:0] k;
            logic [7:0]  t;
            k = keys[a];
            t = tags[a];
            keys[a] = keys[b];
            tags[a] = tags[b];
            keys[b] = k;
            tags[b] = t;
        endfunction

        function void note_request(logic act, logic [15:0] k, logic [7:0] t);
            heap_answer_t a;
            int unsigned  pos;
            int unsigned  left;
            int unsigned  best;
            bit           settled;
            a.status      = STATUS_DONE;
            a.removed_key = '0;
            a.removed_tag = '0;
            if (act == ACT_INSERT) begin
                if (fill >= HEAP_DEPTH)
                    a.status = STATUS_FULL;
                else begin
                    pos = fill;
                    keys[pos] = k;
                    tags[pos] = t;
                    fill++;
                    // climb while the parent is strictly greater
                    while (pos > 0 && keys[(pos - 1) / 2] > keys[pos]) begin
                        swap_slots((pos - 1) / 2, pos);
                        pos = (pos - 1) / 2;
                    end
                end
            end else if (fill == 0)
                a.status = STATUS_EMPTY;
            else begin
                a.removed_key = keys[0];
                a.removed_tag = tags[0];
                fill--;
                keys[0] = keys[fill];
                tags[0] = tags[fill];
                // sink, left child wins a tie
                pos = 0;
                settled = 1'b0;
                while (!settled) begin
                    left = 2 * pos + 1;
                    best = pos;
                    if (left < fill && keys[left] < keys[best])
                        best = left;
                    if (left + 1 < fill && keys[left + 1] < keys[best])
                        best = left + 1;
                    if (best == pos)
                        settled = 1'b1;
                    else begin
                        swap_slots(pos, best);
                        pos = best;
                    end
                end
            end
            a.min_key     = (fill > 0) ? keys[0] : '0;
            a.min_tag     = (fill > 0) ? tags[0] : '0;
            a.entry_total = fill[8:0];
            answers_due.push_back(a);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_answer(logic [1:0] st, logic [63:0] data);
            heap_answer_t a;
            if (answers_due.size() == 0) begin
                $error("result beat with no request outstanding");
                errors++;
                return;
            end
            a = answers_due.pop_front();
            compare_field("status",      16'(a.status),      16'(st));
            compare_field("removed_key", a.removed_key,      data[15:0]);
            compare_field("removed_tag", 16'(a.removed_tag), 16'(data[23:16]));
            compare_field("min_key",     a.min_key,          data[39:24]);
            compare_field("min_tag",     16'(a.min_tag),     16'(data[47:40]));
            compare_field("entry_total", 16'(a.entry_total), 16'(data[56:48]));
        endfunction

        function int unsigned pending();
            return answers_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // key, tag
    logic        s_tuser;   // action
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // removed_key, removed_tag, min_key, min_tag, entry_total
    logic [1:0]  m_tuser;   // status

    heap_scoreboard sb;
    int unsigned    beats_sent;
    int unsigned    quiet_cycles;
    bit             calm;   // when set neither side idles

    min_heap_priority_queue #(
        .DEPTH    (HEAP_DEPTH),
        .KEY_BITS (16),
        .TAG_BITS (8)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // full range, narrow bands at both ends for ties, or the extremes
    function automatic logic [15:0] pick_key();
        case ($urandom_range(0, 5))
            0, 1, 2: return 16'($urandom);
            3:       return 16'($urandom_range(0, 15));
            4:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: return 16'($urandom_range(16'hfff0, 16'hffff));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(logic act, logic [15:0] k, logic [7:0] t);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {t, k};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(act, k, t);
        beats_sent++;
        // re-roll the idle mode now and then so calm stretches appear
        if (beats_sent % 50 == 0)
            calm = ($urandom_range(0, 3) == 0);
        @(negedge clk);
    endtask

    task automatic send_random(int unsigned insert_pct);
        logic act;
        act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_EXTRACT;
        send_beat(act, pick_key(), 8'($urandom));
    endtask

    // result side: ready with random stalls
    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                stall--;
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_answer(m_tuser, m_tdata);
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned n;
        sb           = new();
        beats_sent   = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_INSERT;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty extract, extremes, new root, last entry out, ties
        send_beat(ACT_EXTRACT, 16'hffff, 8'hff);
        send_beat(ACT_INSERT,  16'hffff, 8'hff);
        send_beat(ACT_INSERT,  16'h0000, 8'h00);
        send_beat(ACT_EXTRACT, 16'h0000, 8'h00);
        send_beat(ACT_EXTRACT, 16'h0000, 8'h00);
        send_beat(ACT_EXTRACT, 16'h0000, 8'h00);
        send_beat(ACT_INSERT,  16'h0005, 8'h01);
        send_beat(ACT_INSERT,  16'h0005, 8'h02);
        send_beat(ACT_INSERT,  16'h0005, 8'h03);
        send_beat(ACT_INSERT,  16'h0003, 8'h04);
        send_beat(ACT_INSERT,  16'h0007, 8'h05);
        send_beat(ACT_INSERT,  16'h0003, 8'h06);
        send_beat(ACT_INSERT,  16'h0001, 8'h07);
        repeat (8) send_beat(ACT_EXTRACT, 16'($urandom), 8'($urandom));

        // fill to the brim and knock on the full heap a few times
        while (sb.fill < HEAP_DEPTH)
            send_random(85);
        n = $urandom_range(3, 6);
        repeat (n) send_random(100);

        // drain to empty and knock on the empty heap
        while (sb.fill > 0)
            send_random(15);
        n = $urandom_range(3, 6);
        repeat (n) send_random(0);

        // mixed blocks with a drifting insert share
        while (beats_sent < ITEM_TARGET)
        begin
            n = $urandom_range(30, 70);
            repeat (40) send_random(n);
        end

        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/mhpq_pkg.sv
src/mhpq_ram.sv
src/min_heap_priority_queue.sv
tb/tb_top.sv
